@@ hdl/spsup_pkg.sv @@
// shared types and constants of the sensor presence supervisor
`default_nettype none

package spsup_pkg;

    // transaction kinds on the input channel
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_START = 2'd2
    } op_t;

    // supervisor modes
    typedef enum logic [1:0] {
        MODE_DETECTING = 2'd0,
        MODE_ACTIVE    = 2'd1,
        MODE_LOST      = 2'd2
    } mode_t;

    localparam int ANGLE_W = 12;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;
    localparam int SRC_W   = 2;

    localparam logic [SRC_W-1:0]   SRC_NONE  = 2'd0;
    localparam logic [SRC_W-1:0]   SRC_CAND0 = 2'd1;
    localparam logic [SRC_W-1:0]   SRC_CAND1 = 2'd2;
    localparam logic [SRC_W-1:0]   SRC_CAND2 = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register map
    localparam int          PADDR_W       = 3;
    localparam int          PDATA_W       = 32;
    localparam logic        REG_FAIL_LIM  = 1'b0;
    localparam logic        REG_REDETECT  = 1'b1;
    localparam logic [COUNT_W-1:0] FAIL_LIMIT_RST = 8'd3;
    localparam logic [TIME_W-1:0]  REDETECT_RST   = 32'd1000;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic [COUNT_W-1:0] failure_limit;
        logic [TIME_W-1:0]  redetect_interval;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [TIME_W-1:0]  now_ms;
        logic               cand0_found;
        logic               cand1_found;
        logic               cand2_found;
        logic [ANGLE_W-1:0] cand0_angle;
        logic [ANGLE_W-1:0] cand1_angle;
        logic [ANGLE_W-1:0] cand2_angle;
        logic               read_ok;
        logic [ANGLE_W-1:0] read_angle;
    } item_t;

    typedef struct packed {
        mode_t              mode;
        logic [SRC_W-1:0]   source;
        logic               read_accepted;
        logic               lost_event;
        logic               recovered_event;
        logic [ANGLE_W-1:0] angle_out;
        logic [COUNT_W-1:0] failure_tally;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/sensor_presence_supervisor.sv @@
// top level: stream channels, input and result registers, config port
//
// Usage: each input transaction carries a kind on s_tuser (tick, read outcome,
// start) and the time stamp, candidate probe results and read result on
// s_tdata. Every input transaction produces exactly one result transaction
// on m_tdata with the mode, selected source, event pulses, angle and the
// consecutive failure count after that transaction.
// Path: a transaction accepted into the input register is processed against
// the supervisor state combinationally and moves into the result register,
// which drives m_tvalid, as soon as that register is free.
// Throughput: one transaction per cycle while m_tready stays high; the state
// update is a single pass of compare, priority pick and counter logic between
// the input register and the result register.
// Stall: if m_tready is low the result register holds; the input register
// still takes one more transaction if it is empty, after which s_tready drops
// until the result is taken.
// Reset (aresetn low, synchronous): mode detecting, no source, failure count
// and last attempt time zero, bus not started, failure_limit 3, redetect_interval
// 1000. Registers must be written over apb while idle; the block does not check.
`default_nettype none

module sensor_presence_supervisor (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input channel
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // now_ms[31:0], cand0_found[32], cand1_found[33], cand2_found[34],
    // cand0_angle[46:35], cand1_angle[58:47], cand2_angle[70:59],
    // read_ok[71], read_angle[83:72], zero fill [87:84]
    input  wire logic [spsup_pkg::S_TDATA_W-1:0]     s_tdata,
    // op[1:0]
    input  wire logic [1:0]                          s_tuser,
    // result channel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // mode[1:0], source[3:2], read_accepted[4], lost_event[5],
    // recovered_event[6], angle_out[18:7], failure_tally[26:19], zero fill [31:27]
    output logic      [spsup_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [spsup_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [spsup_pkg::PDATA_W-1:0]       pwdata,
    output logic      [spsup_pkg::PDATA_W-1:0]       prdata,
    output logic                                     pready
);

    spsup_pkg::cfg_t    cfg;
    spsup_pkg::item_t   in_item_reg;
    logic               in_valid_reg;
    spsup_pkg::result_t result;
    spsup_pkg::result_t out_res_reg;
    logic               out_valid_reg;
    logic               out_free;
    logic               advance;
    logic               in_take;

    // handshake control
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg.op          <= spsup_pkg::op_t'(s_tuser);
            in_item_reg.now_ms      <= s_tdata[31:0];
            in_item_reg.cand0_found <= s_tdata[32];
            in_item_reg.cand1_found <= s_tdata[33];
            in_item_reg.cand2_found <= s_tdata[34];
            in_item_reg.cand0_angle <= s_tdata[46:35];
            in_item_reg.cand1_angle <= s_tdata[58:47];
            in_item_reg.cand2_angle <= s_tdata[70:59];
            in_item_reg.read_ok     <= s_tdata[71];
            in_item_reg.read_angle  <= s_tdata[83:72];
        end
    end

    spsup_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spsup_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_res_reg.failure_tally,
                       out_res_reg.angle_out,
                       out_res_reg.recovered_event,
                       out_res_reg.lost_event,
                       out_res_reg.read_accepted,
                       out_res_reg.source,
                       out_res_reg.mode};

endmodule

`default_nettype wire

@@ hdl/spsup_cfg.sv @@
// configuration register file behind the apb port
`default_nettype none

module spsup_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [spsup_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [spsup_pkg::PDATA_W-1:0]    pwdata,
    output logic      [spsup_pkg::PDATA_W-1:0]    prdata,
    output logic                                  pready,
    output spsup_pkg::cfg_t                       cfg
);

    logic [spsup_pkg::COUNT_W-1:0] fail_limit_reg;
    logic [spsup_pkg::TIME_W-1:0]  redetect_reg;
    logic                          wr_en;
    logic                          reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    // register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_limit_reg <= spsup_pkg::FAIL_LIMIT_RST;
            redetect_reg   <= spsup_pkg::REDETECT_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                spsup_pkg::REG_FAIL_LIM: fail_limit_reg <= pwdata[spsup_pkg::COUNT_W-1:0];
                spsup_pkg::REG_REDETECT: redetect_reg   <= pwdata[spsup_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (reg_sel)
            spsup_pkg::REG_FAIL_LIM:
                prdata = {{(spsup_pkg::PDATA_W-spsup_pkg::COUNT_W){1'b0}}, fail_limit_reg};
            spsup_pkg::REG_REDETECT:
                prdata = redetect_reg;
            default:
                prdata = '0;
        endcase
    end

    assign cfg.failure_limit     = fail_limit_reg;
    assign cfg.redetect_interval = redetect_reg;

endmodule

`default_nettype wire

@@ hdl/spsup_core.sv @@
// supervisor state and the per-transaction update logic
`default_nettype none

module spsup_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire spsup_pkg::item_t item,
    input  wire spsup_pkg::cfg_t  cfg,
    output spsup_pkg::result_t   result
);

    spsup_pkg::mode_t               mode_reg, mode_next;
    logic [spsup_pkg::SRC_W-1:0]    source_reg, source_next;
    logic [spsup_pkg::COUNT_W-1:0]  fail_count_reg, fail_count_next;
    logic [spsup_pkg::TIME_W-1:0]   last_attempt_reg, last_attempt_next;
    logic                           bus_started_reg, bus_started_next;

    logic [spsup_pkg::TIME_W-1:0]   elapsed;
    logic [spsup_pkg::COUNT_W-1:0]  fail_inc;
    logic                           det_bus;
    logic                           det_from_lost;
    logic                           det_hit;
    logic [spsup_pkg::SRC_W-1:0]    det_source;
    logic [spsup_pkg::ANGLE_W-1:0]  det_angle;
    logic                           accepted;
    logic                           lost;
    logic                           recovered;
    logic [spsup_pkg::ANGLE_W-1:0]  angle;

    assign elapsed  = item.now_ms - last_attempt_reg;
    assign fail_inc = (fail_count_reg == spsup_pkg::COUNT_MAX) ? fail_count_reg
                                                                : fail_count_reg + 8'd1;

    // priority pick among the three candidates
    assign det_bus = bus_started_reg | (item.op == spsup_pkg::OP_START);
    always_comb begin
        det_hit    = 1'b1;
        det_source = spsup_pkg::SRC_NONE;
        det_angle  = item.cand0_angle;
        if (det_bus && item.cand0_found) begin
            det_source = spsup_pkg::SRC_CAND0;
        end else if (det_bus && item.cand1_found) begin
            det_source = spsup_pkg::SRC_CAND1;
            det_angle  = item.cand1_angle;
        end else if (det_bus && item.cand2_found) begin
            det_source = spsup_pkg::SRC_CAND2;
            det_angle  = item.cand2_angle;
        end else begin
            det_hit = 1'b0;
        end
    end

    // a start forces detecting first, so only a tick can recover
    assign det_from_lost = (item.op == spsup_pkg::OP_TICK) && (mode_reg == spsup_pkg::MODE_LOST);

    // next state and result fields
    always_comb begin
        mode_next         = mode_reg;
        source_next       = source_reg;
        fail_count_next   = fail_count_reg;
        last_attempt_next = last_attempt_reg;
        bus_started_next  = bus_started_reg;
        accepted          = 1'b0;
        lost              = 1'b0;
        recovered         = 1'b0;
        angle             = '0;
        case (item.op)
            spsup_pkg::OP_TICK, spsup_pkg::OP_START: begin
                if (item.op == spsup_pkg::OP_START ||
                    (mode_reg != spsup_pkg::MODE_ACTIVE &&
                     elapsed >= cfg.redetect_interval)) begin
                    if (item.op == spsup_pkg::OP_START) begin
                        bus_started_next = 1'b1;
                    end
                    last_attempt_next = item.now_ms;
                    if (det_hit) begin
                        mode_next       = spsup_pkg::MODE_ACTIVE;
                        source_next     = det_source;
                        fail_count_next = '0;
                        if (det_from_lost) begin
                            recovered = 1'b1;
                            angle     = det_angle;
                        end
                    end else begin
                        source_next = spsup_pkg::SRC_NONE;
                        mode_next   = det_from_lost ? spsup_pkg::MODE_LOST
                                                    : spsup_pkg::MODE_DETECTING;
                    end
                end
            end
            spsup_pkg::OP_READ: begin
                if (source_reg != spsup_pkg::SRC_NONE) begin
                    if (item.read_ok) begin
                        fail_count_next = '0;
                        accepted        = 1'b1;
                        angle           = item.read_angle;
                    end else begin
                        fail_count_next = fail_inc;
                        if (fail_inc >= cfg.failure_limit) begin
                            source_next       = spsup_pkg::SRC_NONE;
                            mode_next         = spsup_pkg::MODE_LOST;
                            lost              = 1'b1;
                            last_attempt_next = item.now_ms;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // state registers, updated once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= spsup_pkg::MODE_DETECTING;
            source_reg       <= spsup_pkg::SRC_NONE;
            fail_count_reg   <= '0;
            last_attempt_reg <= '0;
            bus_started_reg  <= 1'b0;
        end else if (advance) begin
            mode_reg         <= mode_next;
            source_reg       <= source_next;
            fail_count_reg   <= fail_count_next;
            last_attempt_reg <= last_attempt_next;
            bus_started_reg  <= bus_started_next;
        end
    end

    assign result.mode            = mode_next;
    assign result.source          = source_next;
    assign result.read_accepted   = accepted;
    assign result.lost_event      = lost;
    assign result.recovered_event = recovered;
    assign result.angle_out       = angle;
    assign result.failure_tally   = fail_count_next;

    // active mode and a selected candidate always go together
    a_mode_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == spsup_pkg::MODE_ACTIVE) == (source_reg != spsup_pkg::SRC_NONE))
        else $error("active mode without a source or vice versa");

    // lost and recovered never in the same transaction
    a_events_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> !(lost && recovered))
        else $error("lost and recovered pulses together");

    // a lost pulse leaves the block in lost mode with no source
    a_lost_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && lost) |=> (mode_reg == spsup_pkg::MODE_LOST &&
                               source_reg == spsup_pkg::SRC_NONE))
        else $error("lost pulse without entering lost mode");

    // a recovery only comes from a started bus and leaves the block active
    a_recover_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && recovered) |=> (mode_reg == spsup_pkg::MODE_ACTIVE && bus_started_reg))
        else $error("recovered pulse without an active sensor");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// self-checking testbench for the sensor presence supervisor: directed and random transactions
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spsup_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 50;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // supervisor state as the checker sees it
    mode_t              sv_mode      = MODE_DETECTING;
    logic [SRC_W-1:0]   sv_source    = SRC_NONE;
    logic [COUNT_W-1:0] sv_fails     = '0;
    logic [TIME_W-1:0]  sv_last_try  = '0;
    logic               sv_bus_up    = 1'b0;
    logic [COUNT_W-1:0] fail_limit   = FAIL_LIMIT_RST;
    logic [TIME_W-1:0]  retry_period = REDETECT_RST;

    result_t            pending_results[$];
    int                 errors        = 0;
    int                 cycle_count   = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    logic [TIME_W-1:0]  sim_ms        = '0;
    int                 fail_burst    = 0;

    sensor_presence_supervisor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always #10 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // detection: first responding candidate in priority order
    task automatic run_detection(input item_t it, output logic recovered,
                                 output logic [ANGLE_W-1:0] angle);
        logic prev_lost;
        prev_lost   = (sv_mode == MODE_LOST);
        recovered   = 1'b0;
        angle       = '0;
        sv_last_try = it.now_ms;
        if (sv_bus_up && (it.cand0_found || it.cand1_found || it.cand2_found)) begin
            sv_mode  = MODE_ACTIVE;
            sv_fails = '0;
            if (it.cand0_found) begin
                sv_source = SRC_CAND0;
                angle     = it.cand0_angle;
            end else if (it.cand1_found) begin
                sv_source = SRC_CAND1;
                angle     = it.cand1_angle;
            end else begin
                sv_source = SRC_CAND2;
                angle     = it.cand2_angle;
            end
            recovered = prev_lost;
        end else begin
            sv_source = SRC_NONE;
            sv_mode   = prev_lost ? MODE_LOST : MODE_DETECTING;
        end
    endtask

    // advance the supervisor state by one input transaction
    task automatic step_supervisor(input item_t it, output result_t res);
        logic               accepted;
        logic               lost;
        logic               recovered;
        logic [ANGLE_W-1:0] angle;
        logic [TIME_W-1:0]  elapsed;
        accepted  = 1'b0;
        lost      = 1'b0;
        recovered = 1'b0;
        angle     = '0;
        elapsed   = it.now_ms - sv_last_try;
        case (it.op)
            OP_TICK: begin
                if (sv_mode != MODE_ACTIVE && elapsed >= retry_period)
                    run_detection(it, recovered, angle);
            end
            OP_READ: begin
                if (sv_source != SRC_NONE) begin
                    if (it.read_ok) begin
                        sv_fails = '0;
                        accepted = 1'b1;
                        angle    = it.read_angle;
                    end else begin
                        if (sv_fails != COUNT_MAX)
                            sv_fails = sv_fails + 1'b1;
                        if (sv_fails >= fail_limit) begin
                            sv_source   = SRC_NONE;
                            sv_mode     = MODE_LOST;
                            lost        = 1'b1;
                            sv_last_try = it.now_ms;
                        end
                    end
                end
            end
            OP_START: begin
                sv_bus_up = 1'b1;
                sv_mode   = MODE_DETECTING;
                run_detection(it, recovered, angle);
            end
            default: begin
                // unused kind leaves everything as it is
            end
        endcase
        res.mode            = sv_mode;
        res.source          = sv_source;
        res.read_accepted   = accepted;
        res.lost_event      = lost;
        res.recovered_event = recovered;
        res.angle_out       = (accepted || recovered) ? angle : '0;
        res.failure_tally   = sv_fails;
    endtask

    // drive one input transaction and record what it should produce
    task automatic send_item(input item_t it);
        result_t res;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {4'b0000, it.read_angle, it.read_ok, it.cand2_angle, it.cand1_angle,
                     it.cand0_angle, it.cand2_found, it.cand1_found, it.cand0_found,
                     it.now_ms};
        do @(posedge aclk); while (!s_tready);
        step_supervisor(it, res);
        pending_results.push_back(res);
    endtask

    // apb write once all results are back
    task automatic write_register(input logic index, input logic [PDATA_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_FAIL_LIM)
            fail_limit = value[COUNT_W-1:0];
        else
            retry_period = value;
    endtask

    // item with random angles and the given kind, time, candidates and read outcome
    function automatic item_t make_item(input op_t op, input logic [TIME_W-1:0] now,
                                        input logic [2:0] found, input logic ok);
        item_t it;
        it.op          = op;
        it.now_ms      = now;
        it.cand0_found = found[0];
        it.cand1_found = found[1];
        it.cand2_found = found[2];
        it.cand0_angle = ANGLE_W'($urandom);
        it.cand1_angle = ANGLE_W'($urandom);
        it.cand2_angle = ANGLE_W'($urandom);
        it.read_ok     = ok;
        it.read_angle  = ANGLE_W'($urandom);
        return it;
    endfunction

    // mostly plausible traffic: time moves forward, failures come in bursts
    task automatic send_random_traffic(input int count, input int ok_pct);
        op_t  op;
        logic ok;
        int   pick;
        repeat (count) begin
            pick = $urandom_range(99);
            op   = (pick < 8) ? OP_START : (pick < 45) ? OP_TICK : OP_READ;
            if ($urandom_range(99) < 10)
                sim_ms = $urandom;
            else
                sim_ms = sim_ms + $urandom_range(0, 600);
            if (fail_burst > 0) begin
                ok         = 1'b0;
                fail_burst = fail_burst - 1;
            end else if (op == OP_READ && $urandom_range(99) < 15) begin
                ok         = 1'b0;
                fail_burst = $urandom_range(0, fail_limit);
            end else begin
                ok = ($urandom_range(99) < ok_pct);
            end
            send_item(make_item(op, sim_ms, 3'($urandom), ok));
        end
    endtask

    // modes, events and wrap-around with reset register values
    task automatic test_directed_modes();
        item_t it;
        send_item(make_item(OP_TICK, 32'd0, 3'b111, 1'b1));
        send_item(make_item(OP_TICK, 32'd1000, 3'b111, 1'b1));
        send_item(make_item(OP_READ, 32'd1100, 3'b111, 1'b0));
        send_item(make_item(op_t'(2'd3), 32'd1200, 3'b111, 1'b1));
        send_item(make_item(OP_START, 32'd1500, 3'b000, 1'b1));
        send_item(make_item(OP_TICK, 32'd2000, 3'b111, 1'b1));
        it = make_item(OP_TICK, 32'd2500, 3'b100, 1'b1);
        it.cand2_angle = '1;
        send_item(it);
        send_item(make_item(OP_TICK, 32'hFFFF_FFFF, 3'b111, 1'b1));
        it = make_item(OP_READ, 32'd2600, 3'b000, 1'b1);
        it.read_angle = '1;
        send_item(it);
        it = make_item(OP_READ, 32'd2700, 3'b000, 1'b1);
        it.read_angle = '0;
        send_item(it);
        // a success in between clears the failure count
        send_item(make_item(OP_READ, 32'd2800, 3'b000, 1'b0));
        send_item(make_item(OP_READ, 32'd2900, 3'b000, 1'b0));
        send_item(make_item(OP_READ, 32'd2950, 3'b000, 1'b1));
        repeat (3) send_item(make_item(OP_READ, 32'd3000, 3'b000, 1'b0));
        send_item(make_item(OP_READ, 32'd3100, 3'b111, 1'b1));
        send_item(make_item(OP_TICK, 32'd3999, 3'b111, 1'b1));
        send_item(make_item(OP_TICK, 32'd4000, 3'b000, 1'b1));
        it = make_item(OP_TICK, 32'd5000, 3'b010, 1'b1);
        it.cand1_angle = '1;
        send_item(it);
        repeat (3) send_item(make_item(OP_READ, 32'd6000, 3'b000, 1'b0));
        // start while lost gives no recovery pulse
        send_item(make_item(OP_START, 32'd6000, 3'b111, 1'b1));
        repeat (3) send_item(make_item(OP_READ, 32'hFFFF_FF00, 3'b000, 1'b0));
        // elapsed time across the wrap of the millisecond counter
        it = make_item(OP_TICK, 32'h0000_02E8, 3'b001, 1'b1);
        it.cand0_angle = 12'hABC;
        send_item(it);
        sim_ms = 32'd10000;
    endtask

    // failure limit at zero and at its maximum
    task automatic test_limit_extremes();
        write_register(REG_FAIL_LIM, 32'd0);
        send_item(make_item(OP_START, sim_ms, 3'b001, 1'b1));
        send_item(make_item(OP_READ, sim_ms, 3'b000, 1'b1));
        send_item(make_item(OP_READ, sim_ms, 3'b000, 1'b0));
        write_register(REG_FAIL_LIM, 32'd255);
        send_item(make_item(OP_START, sim_ms, 3'b010, 1'b1));
        repeat (256) begin
            sim_ms = sim_ms + $urandom_range(0, 20);
            send_item(make_item(OP_READ, sim_ms, 3'($urandom), 1'b0));
        end
    endtask

    // re-detect interval at zero and at its maximum
    task automatic test_interval_extremes();
        write_register(REG_FAIL_LIM, 32'd2);
        write_register(REG_REDETECT, 32'd0);
        send_item(make_item(OP_START, sim_ms, 3'b000, 1'b1));
        send_item(make_item(OP_TICK, sim_ms, 3'b000, 1'b1));
        send_item(make_item(OP_TICK, sim_ms, 3'b100, 1'b1));
        send_item(make_item(OP_TICK, sim_ms, 3'b111, 1'b1));
        repeat (2) send_item(make_item(OP_READ, sim_ms + 32'd5, 3'b000, 1'b0));
        send_item(make_item(OP_TICK, sim_ms + 32'd5, 3'b010, 1'b1));
        write_register(REG_REDETECT, 32'hFFFF_FFFF);
        sim_ms = sim_ms + 32'd100;
        repeat (2) send_item(make_item(OP_READ, sim_ms, 3'b000, 1'b0));
        send_item(make_item(OP_TICK, sv_last_try + 32'hFFFF_FFFE, 3'b111, 1'b1));
        send_item(make_item(OP_TICK, sv_last_try + 32'hFFFF_FFFF, 3'b001, 1'b1));
    endtask

    // random traffic under one register setting
    task automatic test_random_setting(input logic [COUNT_W-1:0] limit,
                                       input logic [TIME_W-1:0] period,
                                       input int count, input int ok_pct);
        write_register(REG_FAIL_LIM, PDATA_W'(limit));
        write_register(REG_REDETECT, period);
        send_random_traffic(count, ok_pct);
    endtask

    // field compare with report
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors = errors + 1;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    // result channel checker
    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("mode", want.mode, m_tdata[1:0]);
                check_field("source", want.source, m_tdata[3:2]);
                check_field("read_accepted", want.read_accepted, m_tdata[4]);
                check_field("lost_event", want.lost_event, m_tdata[5]);
                check_field("recovered_event", want.recovered_event, m_tdata[6]);
                check_field("angle_out", want.angle_out, m_tdata[18:7]);
                check_field("failure_tally", want.failure_tally, m_tdata[26:19]);
            end
        end
    end

    // run time guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count = cycle_count + 1;
        end
        $display("TB_ERROR");
        $finish;
    end

    // test sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 14;
        recv_idle_pct = 52;
        test_directed_modes();
        test_random_setting(8'd3, 32'd1000, 120, 70);

        send_idle_pct = 52;
        recv_idle_pct = 14;
        test_limit_extremes();
        test_interval_extremes();
        test_random_setting(8'd1, 32'd40, 120, 80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_setting(8'd5, 32'd300, 111, 60);

        // drain
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/spsup_pkg.sv
hdl/spsup_cfg.sv
hdl/spsup_core.sv
hdl/sensor_presence_supervisor.sv
tb/sv/testbench.sv
